// ----- sv/fea_pkg.sv -----
// fea_pkg: shared types and codes for the free extent allocator
// used by fea_ctrl, fea_dp and free_extent_allocator_core
package fea_pkg;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_MARK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_WRITE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_TOTAL = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic check;      // range check, init update
    logic rd_scan;    // read entry at scan index
    logic eval;       // evaluate scanned entry
    logic decide;     // compute the outcome
    logic write;      // apply the update
    logic shift_rd;   // read next shift source
    logic shift_wr;   // write shift destination
    logic finish;     // present result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;        // request fails early
    logic immediate;  // request is done without scanning
    logic scan_end;   // scan index reached count
    logic hit;        // scanned entry ends the search
    logic do_shift;   // table entries must move
    logic shift_end;  // shift loop finished
  } sts_t;

endpackage

// ----- sv/fea_ctrl.sv -----
// fea_ctrl: sequencer for one request at a time
// depends on fea_pkg
module fea_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  fea_pkg::sts_t  sts,
  output fea_pkg::cmd_t  cmd
);

  fea_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= fea_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      fea_pkg::S_IDLE:
        if (start) state_next = fea_pkg::S_CHECK;
      fea_pkg::S_CHECK: begin
        if (sts.bad || sts.immediate) state_next = fea_pkg::S_DONE;
        else                          state_next = fea_pkg::S_SCAN_RD;
      end
      fea_pkg::S_SCAN_RD: begin
        if (sts.scan_end) state_next = fea_pkg::S_DECIDE;
        else              state_next = fea_pkg::S_SCAN_EV;
      end
      fea_pkg::S_SCAN_EV: begin
        if (sts.hit) state_next = fea_pkg::S_DECIDE;
        else         state_next = fea_pkg::S_SCAN_RD;
      end
      fea_pkg::S_DECIDE:   state_next = fea_pkg::S_WRITE;
      fea_pkg::S_WRITE: begin
        if (sts.do_shift) state_next = fea_pkg::S_SHIFT_RD;
        else              state_next = fea_pkg::S_DONE;
      end
      fea_pkg::S_SHIFT_RD: begin
        if (sts.shift_end) state_next = fea_pkg::S_DONE;
        else               state_next = fea_pkg::S_SHIFT_WR;
      end
      fea_pkg::S_SHIFT_WR: state_next = fea_pkg::S_SHIFT_RD;
      fea_pkg::S_DONE:     state_next = fea_pkg::S_IDLE;
      default:             state_next = fea_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != fea_pkg::S_IDLE);
    case (state)
      fea_pkg::S_IDLE:     cmd.load = start;
      fea_pkg::S_CHECK:    cmd.check = 1'b1;
      fea_pkg::S_SCAN_RD:  cmd.rd_scan = 1'b1;
      fea_pkg::S_SCAN_EV:  cmd.eval = 1'b1;
      fea_pkg::S_DECIDE:   cmd.decide = 1'b1;
      fea_pkg::S_WRITE:    cmd.write = 1'b1;
      fea_pkg::S_SHIFT_RD: cmd.shift_rd = 1'b1;
      fea_pkg::S_SHIFT_WR: cmd.shift_wr = 1'b1;
      fea_pkg::S_DONE:     cmd.finish = 1'b1;
      default:             cmd = '0;
    endcase
  end

endmodule

// ----- sv/fea_dp.sv -----
// fea_dp: extent table memory, scan registers and update arithmetic
// depends on fea_pkg
module fea_dp #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fea_pkg::cmd_t        cmd,
  output fea_pkg::sts_t        sts,
  input  logic [1:0]           req_type,
  input  logic [63:0]          range_offset,
  input  logic [63:0]          range_length,
  input  logic [63:0]          base_offset,
  input  logic [63:0]          total_length,
  output logic                 done,
  output logic [2:0]           status,
  output logic [63:0]          alloc_offset,
  output logic [63:0]          free_total
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);

  // table memory, one 128-bit word per extent {start, size}
  logic [127:0]  mem [MAX_EXTENTS];
  logic [127:0]  rdata;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [127:0]  wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  logic [1:0]    req;
  logic [63:0]   off, len;
  logic [CW-1:0] count, idx, k;
  logic [63:0]   fbc;
  logic [63:0]   cs, csz, ps, psz;   // hit entry and the entry before it
  logic          found;
  fea_pkg::status_t st;
  logic [63:0]   got;
  logic          grow;               // shift opens a slot, else closes one
  logic          need_shift;
  logic          wa_en, wb_en;       // write before the shift, write after it
  logic [IW-1:0] wa_addr, wb_addr;
  logic [127:0]  wa_data, wb_data;

  logic [63:0] end_r, rend;
  logic        range_good;
  assign end_r = off + len;
  assign rend  = base_offset + total_length;
  assign range_good = (len != 64'd0) && (off >= base_offset) && (end_r >= off) &&
                      (rend >= base_offset) && (end_r <= rend);

  logic [63:0] rd_s, rd_z, rd_e;
  assign rd_s = rdata[127:64];
  assign rd_z = rdata[63:0];
  assign rd_e = rd_s + rd_z;

  logic hit_now;
  always_comb begin
    case (req)
      fea_pkg::REQ_ALLOC: hit_now = (rd_z >= len);
      fea_pkg::REQ_FREE:  hit_now = !(rd_s < off);
      default:            hit_now = (rd_e > off);
    endcase
  end

  // decision terms
  logic [63:0] ce, pe, ne;
  logic hp, hn, left, right, ovl;
  assign ce = cs + csz;
  assign pe = ps + psz;
  assign hp = (idx != '0);
  assign hn = found;
  assign ne = end_r;
  assign ovl = (hp && !(pe <= off || ne <= ps)) || (hn && !(ne <= cs || ce <= off));
  assign left  = hp && (pe == off);
  assign right = hn && (ne == cs);

  always_comb begin
    sts = '0;
    case (req)
      fea_pkg::REQ_INIT:  sts.bad = 1'b0;
      fea_pkg::REQ_ALLOC: sts.bad = (len == 64'd0);
      default:            sts.bad = !range_good;
    endcase
    sts.immediate = (req == fea_pkg::REQ_INIT);
    sts.scan_end  = (idx >= count);
    sts.hit       = hit_now;
    sts.do_shift  = need_shift;
    sts.shift_end = grow ? (k <= idx) : (k + CW'(1) >= count);
  end

  always_comb begin
    re = 1'b0;
    raddr = idx[IW-1:0];
    if (cmd.rd_scan && !sts.scan_end) re = 1'b1;
    if (cmd.shift_rd && !sts.shift_end) begin
      re = 1'b1;
      raddr = grow ? IW'(k - CW'(1)) : IW'(k + CW'(1));
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = wa_addr;
    wdata = wa_data;
    if (cmd.write && wa_en) we = 1'b1;
    if (cmd.shift_wr) begin
      we = 1'b1; waddr = k[IW-1:0]; wdata = rdata;
    end
    if (cmd.shift_rd && sts.shift_end && wb_en) begin
      we = 1'b1; waddr = wb_addr; wdata = wb_data;
    end
    // init writes the single region extent
    if (cmd.check && sts.immediate && total_length != 64'd0) begin
      we = 1'b1; waddr = '0; wdata = {base_offset, total_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fbc   <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        req <= req_type; off <= range_offset; len <= range_length;
        idx <= '0; found <= 1'b0; st <= fea_pkg::ST_OK; got <= '0;
        need_shift <= 1'b0; grow <= 1'b0; wa_en <= 1'b0; wb_en <= 1'b0;
      end
      if (cmd.check) begin
        if (sts.immediate) begin
          if (total_length == 64'd0) begin
            count <= '0; fbc <= '0; st <= fea_pkg::ST_INVALID;
          end else begin
            count <= CW'(1); fbc <= total_length;
          end
        end else if (sts.bad) begin
          st <= fea_pkg::ST_INVALID;
        end
      end
      if (cmd.eval) begin
        if (hit_now) begin
          found <= 1'b1; cs <= rd_s; csz <= rd_z;
        end else begin
          idx <= idx + CW'(1);
          ps <= rd_s; psz <= rd_z;
        end
      end
      if (cmd.decide) begin
        case (req)
          fea_pkg::REQ_ALLOC: begin
            if (!found) st <= fea_pkg::ST_NOSPACE;
            else begin
              got <= cs;
              fbc <= fbc - len;
              if (csz == len) begin
                need_shift <= 1'b1; k <= idx; grow <= 1'b0;
              end else begin
                wa_en <= 1'b1; wa_addr <= idx[IW-1:0];
                wa_data <= {cs + len, csz - len};
              end
            end
          end
          fea_pkg::REQ_FREE: begin
            if (ovl) st <= fea_pkg::ST_INVALID;
            else if (left && right) begin
              wa_en <= 1'b1; wa_addr <= IW'(idx - CW'(1));
              wa_data <= {ps, psz + len + csz};
              need_shift <= 1'b1; k <= idx; grow <= 1'b0;
              fbc <= fbc + len;
            end else if (left) begin
              wa_en <= 1'b1; wa_addr <= IW'(idx - CW'(1));
              wa_data <= {ps, psz + len}; fbc <= fbc + len;
            end else if (right) begin
              wa_en <= 1'b1; wa_addr <= idx[IW-1:0];
              wa_data <= {off, csz + len}; fbc <= fbc + len;
            end else if (count >= MAXC) st <= fea_pkg::ST_FULL;
            else begin
              wb_en <= 1'b1; wb_addr <= idx[IW-1:0];
              wb_data <= {off, len}; fbc <= fbc + len;
              need_shift <= 1'b1; k <= count; grow <= 1'b1;
            end
          end
          default: begin
            if (!found || !(cs <= off && ne <= ce)) st <= fea_pkg::ST_NOTFOUND;
            else if (cs == off && ce == ne) begin
              need_shift <= 1'b1; k <= idx; grow <= 1'b0; fbc <= fbc - len;
            end else if (cs == off) begin
              wa_en <= 1'b1; wa_addr <= idx[IW-1:0];
              wa_data <= {cs + len, csz - len}; fbc <= fbc - len;
            end else if (ce == ne) begin
              wa_en <= 1'b1; wa_addr <= idx[IW-1:0];
              wa_data <= {cs, csz - len}; fbc <= fbc - len;
            end else if (count >= MAXC) st <= fea_pkg::ST_FULL;
            else begin
              // shrink the left part now, insert the right part after shifting
              wa_en <= 1'b1; wa_addr <= idx[IW-1:0];
              wa_data <= {cs, off - cs};
              wb_en <= 1'b1; wb_addr <= IW'(idx + CW'(1));
              wb_data <= {ne, ce - ne}; fbc <= fbc - len;
              need_shift <= 1'b1; k <= count; grow <= 1'b1;
              idx <= idx + CW'(1);
            end
          end
        endcase
      end
      if (cmd.shift_wr) k <= grow ? k - CW'(1) : k + CW'(1);
      if (cmd.shift_rd && sts.shift_end)
        count <= grow ? count + CW'(1) : count - CW'(1);
      if (cmd.finish) begin
        status <= st;
        alloc_offset <= (st == fea_pkg::ST_OK) ? got : 64'd0;
      end
    end
  end

  assign free_total = fbc;

endmodule

// ----- sv/free_extent_allocator_core.sv -----
// free extent allocator: a request is accepted when start is high and busy is low, and its
// result is marked by result_valid, high for one cycle; status and alloc_offset hold until the
// next result. The receiver cannot stall. A request scans the table entries one at a time
// through the table memory, each read and then evaluated, and may then move entries to open
// or close a slot; init and rejected requests skip the scan. The block takes one request at
// a time.
module free_extent_allocator_core #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] range_offset,
  input  logic [63:0] range_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [63:0] alloc_offset,
  output logic [63:0] free_total
);

  logic [63:0] base_offset, total_length;
  fea_pkg::cmd_t cmd;
  fea_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= '0;
      total_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fea_pkg::CFG_BASE)  base_offset <= cfg_data;
      if (cfg_index == fea_pkg::CFG_TOTAL) total_length <= cfg_data;
    end
  end

  fea_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .cmd);

  fea_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
    .clk, .rst, .cmd, .sts, .req_type, .range_offset, .range_length,
    .base_offset, .total_length, .done(result_valid), .status, .alloc_offset, .free_total
  );

  a_one_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe repeated");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without request");
  a_no_offset_on_fail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != fea_pkg::ST_OK) |-> alloc_offset == 64'd0)
    else $error("offset on failed request");

endmodule

// ----- bench/fea_checker.sv -----
// fea_checker: predicts free extent allocator results and compares them
// depends on fea_pkg; watches the request, config and result ports of the core
`timescale 1ns / 1ps
module fea_checker #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] range_offset,
  input  logic [63:0] range_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        result_valid,
  input  logic [2:0]  status,
  input  logic [63:0] alloc_offset,
  input  logic [63:0] free_total,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    fea_pkg::status_t st;
    logic [63:0]      got;
    logic [63:0]      freeb;
  } answer_t;

  logic [63:0] m_base, m_total;
  logic [63:0] ext_start [MAX_EXTENTS];
  logic [63:0] ext_size  [MAX_EXTENTS];
  int          ext_cnt;
  logic [63:0] m_free;
  answer_t     answers [$];

  assign pending = answers.size();

  function automatic bit in_region(logic [63:0] off, logic [63:0] len);
    logic [63:0] e, re;
    e  = off + len;
    re = m_base + m_total;
    if (len == 0 || off < m_base || e < off || re < m_base) return 0;
    return e <= re;
  endfunction

  function automatic bit spans_overlap(logic [63:0] ao, logic [63:0] al,
                                       logic [63:0] bo, logic [63:0] bl);
    return !((ao + al) <= bo || (bo + bl) <= ao);
  endfunction

  function automatic void open_at(int i);
    for (int k = ext_cnt; k > i; k--) begin
      ext_start[k] = ext_start[k-1];
      ext_size[k]  = ext_size[k-1];
    end
    ext_cnt++;
  endfunction

  function automatic void close_at(int i);
    for (int k = i; k + 1 < ext_cnt; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_size[k]  = ext_size[k+1];
    end
    ext_cnt--;
  endfunction

  function automatic fea_pkg::status_t serve(fea_pkg::req_t rq, logic [63:0] off,
                                             logic [63:0] len, output logic [63:0] got);
    int i;
    bit hp, hn, lft, rgt;
    logic [63:0] cs, ce, re;
    got = 0;
    i = 0;
    case (rq)
      fea_pkg::REQ_INIT: begin
        ext_cnt = 0;
        m_free = 0;
        if (m_total == 0) return fea_pkg::ST_INVALID;
        ext_start[0] = m_base;
        ext_size[0] = m_total;
        ext_cnt = 1;
        m_free = m_total;
        return fea_pkg::ST_OK;
      end
      fea_pkg::REQ_ALLOC: begin
        if (len == 0) return fea_pkg::ST_INVALID;
        for (i = 0; i < ext_cnt; i++)
          if (ext_size[i] >= len) begin
            got = ext_start[i];
            ext_start[i] += len;
            ext_size[i] -= len;
            m_free -= len;
            if (ext_size[i] == 0) close_at(i);
            return fea_pkg::ST_OK;
          end
        return fea_pkg::ST_NOSPACE;
      end
      fea_pkg::REQ_FREE: begin
        if (!in_region(off, len)) return fea_pkg::ST_INVALID;
        while (i < ext_cnt && ext_start[i] < off) i++;
        hp = i > 0;
        hn = i < ext_cnt;
        if (hp && spans_overlap(ext_start[i-1], ext_size[i-1], off, len))
          return fea_pkg::ST_INVALID;
        if (hn && spans_overlap(off, len, ext_start[i], ext_size[i]))
          return fea_pkg::ST_INVALID;
        lft = hp && (ext_start[i-1] + ext_size[i-1] == off);
        rgt = hn && (off + len == ext_start[i]);
        if (lft && rgt) begin
          ext_size[i-1] += len + ext_size[i];
          close_at(i);
        end else if (lft) begin
          ext_size[i-1] += len;
        end else if (rgt) begin
          ext_start[i] = off;
          ext_size[i] += len;
        end else begin
          if (ext_cnt >= MAX_EXTENTS) return fea_pkg::ST_FULL;
          open_at(i);
          ext_start[i] = off;
          ext_size[i] = len;
        end
        m_free += len;
        return fea_pkg::ST_OK;
      end
      default: begin
        if (!in_region(off, len)) return fea_pkg::ST_INVALID;
        while (i < ext_cnt && ext_start[i] + ext_size[i] <= off) i++;
        if (i >= ext_cnt) return fea_pkg::ST_NOTFOUND;
        cs = ext_start[i];
        ce = cs + ext_size[i];
        re = off + len;
        if (!(cs <= off && re <= ce)) return fea_pkg::ST_NOTFOUND;
        if (cs == off && ce == re) begin
          close_at(i);
        end else if (cs == off) begin
          ext_start[i] += len;
          ext_size[i] -= len;
        end else if (ce == re) begin
          ext_size[i] -= len;
        end else begin
          if (ext_cnt >= MAX_EXTENTS) return fea_pkg::ST_FULL;
          open_at(i + 1);
          ext_start[i+1] = re;
          ext_size[i+1] = ce - re;
          ext_size[i] = off - cs;
        end
        m_free -= len;
        return fea_pkg::ST_OK;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    answer_t a, w;
    logic [63:0] g;
    if (rst) begin
      m_base <= 0;
      m_total <= 0;
      ext_cnt = 0;
      m_free = 0;
      answers.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == fea_pkg::CFG_BASE) m_base <= cfg_data;
        else if (cfg_index == fea_pkg::CFG_TOTAL) m_total <= cfg_data;
      end
      if (start && !busy) begin
        a.st = serve(fea_pkg::req_t'(req_type), range_offset, range_length, g);
        a.got = g;
        a.freeb = m_free;
        answers.push_back(a);
      end
      if (result_valid) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result status=%0d", $time, status);
          fail_count <= fail_count + 1;
        end else begin
          w = answers.pop_front();
          if (status !== w.st || alloc_offset !== w.got || free_total !== w.freeb) begin
            $display("%0t: mismatch expected st=%0d off=%h free=%h actual st=%0d off=%h free=%h",
                     $time, w.st, w.got, w.freeb, status, alloc_offset, free_total);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- bench/tb_top.sv -----
// tb_top: stimulus and verdict for free_extent_allocator_core
// depends on fea_pkg, fea_checker and the core itself
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG = 20000;

  logic clk = 0, rst = 1;
  logic start = 0, cfg_we = 0;
  logic [1:0] req_type = 0, cfg_index = 0;
  logic [63:0] range_offset = 0, range_length = 0, cfg_data = 0;
  logic busy, result_valid;
  logic [2:0] status;
  logic [63:0] alloc_offset, free_total;
  int fail_count, pending, idle_cycles;
  int gap_pct;
  logic [63:0] cur_base, cur_total;

  free_extent_allocator_core uut (.*);
  fea_checker chk (.*);

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles > WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == fea_pkg::CFG_BASE) cur_base = val; else cur_total = val;
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // start stays high from one request to the next; it drops only for gaps and drains
  task automatic send(fea_pkg::req_t rq, logic [63:0] off, logic [63:0] len);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; req_type <= rq; range_offset <= off; range_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random request mostly inside a small region so cuts and merges happen
  task automatic rand_req();
    fea_pkg::req_t rq;
    logic [63:0] off, len;
    int r;
    r = $urandom_range(99);
    rq = r < 3 ? fea_pkg::REQ_INIT : r < 35 ? fea_pkg::REQ_ALLOC :
         r < 70 ? fea_pkg::REQ_FREE : fea_pkg::REQ_MARK;
    off = cur_base + 64'($urandom_range(32'(cur_total < 64'd4096 ? cur_total : 64'd4096)));
    len = 64'($urandom_range(1, 96));
    if ($urandom_range(19) == 0) off = {$urandom, $urandom};
    if ($urandom_range(19) == 0) len = {$urandom, $urandom};
    if ($urandom_range(29) == 0) len = 0;
    send(rq, off, len);
  endtask

  initial begin
    cur_base = 0; cur_total = 0; gap_pct = 9;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // before init, and failed init with zero length
    send(fea_pkg::REQ_ALLOC, 0, 8);
    send(fea_pkg::REQ_MARK, 0, 8);
    send(fea_pkg::REQ_FREE, 0, 8);
    send(fea_pkg::REQ_INIT, 0, 0);
    drain();
    write_reg(fea_pkg::CFG_BASE, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(fea_pkg::CFG_TOTAL, 64'h200);
    send(fea_pkg::REQ_INIT, 0, 0);          // region end wraps
    send(fea_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_FF10, 4);
    drain();
    write_reg(fea_pkg::CFG_BASE, 64'h1000);
    write_reg(fea_pkg::CFG_TOTAL, 64'h1000);
    send(fea_pkg::REQ_INIT, 0, 0);
    send(fea_pkg::REQ_ALLOC, 0, 0);
    send(fea_pkg::REQ_ALLOC, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(fea_pkg::REQ_ALLOC, 0, 16);
    send(fea_pkg::REQ_MARK, 64'h1100, 16);  // middle cut
    send(fea_pkg::REQ_MARK, 64'h1110, 16);  // head cut
    send(fea_pkg::REQ_MARK, 64'h10F0, 16);  // tail cut
    send(fea_pkg::REQ_MARK, 64'h1100, 16);  // not contained
    send(fea_pkg::REQ_FREE, 64'h1100, 32);  // merge right
    send(fea_pkg::REQ_FREE, 64'h1008, 4);   // no neighbour, new entry
    send(fea_pkg::REQ_FREE, 64'h0FFF, 4);   // below base
    send(fea_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20);
    send(fea_pkg::REQ_FREE, 64'h1000, 16);  // overlap
    send(fea_pkg::REQ_MARK, 64'h1000, 64'h1000); // not contained
    for (int i = 0; i < 66; i++)
      send(fea_pkg::REQ_FREE, 64'h1000 + 64'(8 * i), 4); // free 4 bytes every 8 from the base
    send(fea_pkg::REQ_MARK, 64'h1001, 1);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = ph == 0 ? 9 : ph == 1 ? 53 : 0;
      case (ph)
        0: begin
          write_reg(fea_pkg::CFG_BASE, 0); write_reg(fea_pkg::CFG_TOTAL, 64'h800);
        end
        1: begin
          write_reg(fea_pkg::CFG_BASE, 64'h4000_0000);
          write_reg(fea_pkg::CFG_TOTAL, 64'h1000);
        end
        default: begin
          write_reg(fea_pkg::CFG_BASE, 64'h10);
          write_reg(fea_pkg::CFG_TOTAL, 64'hFFFF_FFFF_FFFF_FFEF);
        end
      endcase
      send(fea_pkg::REQ_INIT, 0, 0);
      for (int n = 0; n < 450; n++) begin
        rand_req();
        if (n == 200) drain();
      end
      drain();
    end
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
